>>> hdl/kvz_pkg.sv
// Shared types and codes for the key/velocity zone lookup.
package kvz_pkg;

   localparam int ZONE_INDEX_W = 6;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_FIND  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] instrument_id;
      logic [6:0] note_key;
      logic [6:0] note_velocity;
      logic [6:0] zone_key_low;
      logic [6:0] zone_key_high;
      logic [6:0] zone_vel_low;
      logic [6:0] zone_vel_high;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [ZONE_INDEX_W-1:0] zone_index;
   } rsp_type;

   // one stored zone
   typedef struct packed {
      logic [7:0] instrument;
      logic [6:0] min_key;
      logic [6:0] max_key;
      logic [6:0] min_vel;
      logic [6:0] max_vel;
   } zone_type;

   // lookup that walks the cell chain, one cell per cycle
   typedef struct packed {
      logic                    active;
      logic                    found;
      logic [7:0]              instrument;
      logic [6:0]              key;
      logic [6:0]              vel;
      logic [ZONE_INDEX_W-1:0] index;
   } probe_type;

   // slot write broadcast to every cell
   typedef struct packed {
      logic     en;
      zone_type zone;
   } zone_wr_type;

endpackage

>>> hdl/kvz_cell.sv
// One zone slot of the chain: holds a zone and checks the passing probe.
module kvz_cell
   import kvz_pkg::*;
#(
   parameter int CELL_INDEX = 0,
   parameter int CNT_W      = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] zone_count,
   input  zone_wr_type      zone_wr,
   input  probe_type        prev_probe,
   output probe_type        next_probe
);

   zone_type  zone_ff;
   probe_type probe_ff;
   probe_type probe_in;
   logic      occupied;
   logic      hit;

   assign occupied = CNT_W'(CELL_INDEX) < zone_count;

   always_comb begin
      hit = occupied
         && (zone_ff.instrument == prev_probe.instrument)
         && (prev_probe.key >= zone_ff.min_key)
         && (prev_probe.key <= zone_ff.max_key)
         && ((zone_ff.min_vel == zone_ff.max_vel)
             || ((prev_probe.vel >= zone_ff.min_vel)
                 && (prev_probe.vel <= zone_ff.max_vel)));
      probe_in = prev_probe;
      if (prev_probe.active && !prev_probe.found && hit) begin
         probe_in.found = 1'b1;
         probe_in.index = ZONE_INDEX_W'(CELL_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (zone_wr.en && (zone_count == CNT_W'(CELL_INDEX))) begin
         zone_ff <= zone_wr.zone;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.active <= 1'b0;
      end else begin
         probe_ff.active <= probe_in.active;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff.found      <= probe_in.found;
      probe_ff.instrument <= probe_in.instrument;
      probe_ff.key        <= probe_in.key;
      probe_ff.vel        <= probe_in.vel;
      probe_ff.index      <= probe_in.index;
   end

   assign next_probe = probe_ff;

endmodule

>>> hdl/key_velocity_zone_lookup.sv
// Top level: zone table as a chain of cells, with command decode and result register.
// Clear, add, unused opcode: result valid the cycle after the request beat is taken.
// Find: the probe walks one cell per cycle; the result is registered once the probe
//   leaves the last cell, so the cell chain length sets how long a find takes.
// One request in flight at a time; a new request beat is taken once idle and the
//   result register is empty or draining in the same cycle.
// Reset (synchronous, active high) empties the table and drops all valids.
module key_velocity_zone_lookup
   import kvz_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic        req_accept;
   logic        table_full;
   zone_wr_type zone_wr;
   probe_type   probe_chain [TABLE_DEPTH+1];
   probe_type   tail;

   // result register must be free (or freeing) before a new beat comes in
   assign req_ready  = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;
   assign table_full = count_ff >= CNT_W'(TABLE_DEPTH);

   // slot write goes to the cell whose index equals the current count
   assign zone_wr.en              = req_accept && (req_data.opcode == OP_ADD) && !table_full;
   assign zone_wr.zone.instrument = req_data.instrument_id;
   assign zone_wr.zone.min_key    = req_data.zone_key_low;
   assign zone_wr.zone.max_key    = req_data.zone_key_high;
   assign zone_wr.zone.min_vel    = req_data.zone_vel_low;
   assign zone_wr.zone.max_vel    = req_data.zone_vel_high;

   // probe injected at the head of the chain
   always_comb begin
      probe_chain[0].active     = req_accept && (req_data.opcode == OP_FIND);
      probe_chain[0].found      = 1'b0;
      probe_chain[0].instrument = req_data.instrument_id;
      probe_chain[0].key        = req_data.note_key;
      probe_chain[0].vel        = req_data.note_velocity;
      probe_chain[0].index      = '0;
   end

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      kvz_cell #(
         .CELL_INDEX (g),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .zone_count (count_ff),
         .zone_wr    (zone_wr),
         .prev_probe (probe_chain[g]),
         .next_probe (probe_chain[g+1])
      );
   end

   assign tail = probe_chain[TABLE_DEPTH];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_accept) begin
         rsp_in.status     = ST_OK;
         rsp_in.zone_index = '0;
         case (req_data.opcode)
            OP_CLEAR: begin
               count_in     = '0;
               rsp_valid_in = 1'b1;
            end
            OP_ADD: begin
               rsp_valid_in = 1'b1;
               if (table_full) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  rsp_in.zone_index = ZONE_INDEX_W'(count_ff);
                  count_in          = count_ff + CNT_W'(1);
               end
            end
            OP_FIND: begin
               state_in = S_SCAN;
            end
            default: begin
               // unused opcode: no state change, plain ok beat
               rsp_valid_in = 1'b1;
            end
         endcase
      end

      // probe left the last cell: scan is over
      if ((state_ff == S_SCAN) && tail.active) begin
         state_in          = S_IDLE;
         rsp_valid_in      = 1'b1;
         rsp_in.status     = tail.found ? ST_OK : ST_NOT_FOUND;
         rsp_in.zone_index = tail.index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> sim/tb_key_velocity_zone_lookup.sv
// Self-checking testbench for the key/velocity zone lookup table.
module tb_key_velocity_zone_lookup
   import kvz_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 64;
   localparam int ITEM_TARGET = 1600;
   // Items past this count run with both sides idle-free
   localparam int QUIET_AFTER = 1350;
   // Drain margin covers a find walking the whole cell chain
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;

   // Opcode 3 is unused by the block: one beat in, one status-ok beat out
   localparam logic [1:0] OP_NOP = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   key_velocity_zone_lookup #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Zone table shadow: same fill order and first-match scan as the block
   // ------------------------------------------------------------------
   zone_type shadow_zones [TABLE_DEPTH];
   int       shadow_count = 0;

   // Results still owed by the block, oldest first
   rsp_type  owed_results [$];

   int       mismatches = 0;
   int       items_sent = 0;
   bit       tx_idle_en = 1'b0;
   bit       rx_idle_en = 1'b0;
   int       rx_stall_left = 0;

   // Appends one result to the owed list
   function automatic void owe_result(input rsp_type r);
      owed_results = {owed_results, r};
   endfunction

   // Applies one accepted request beat to the shadow table, returns the result
   function automatic rsp_type apply_zone_cmd(input req_type b);
      rsp_type  r;
      zone_type z;
      r.status     = ST_OK;
      r.zone_index = '0;
      case (b.opcode)
         OP_CLEAR: begin
            shadow_count = 0;
         end
         OP_ADD: begin
            if (shadow_count >= TABLE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               z.instrument = b.instrument_id;
               z.min_key    = b.zone_key_low;
               z.max_key    = b.zone_key_high;
               z.min_vel    = b.zone_vel_low;
               z.max_vel    = b.zone_vel_high;
               shadow_zones[shadow_count] = z;
               r.zone_index = shadow_count[ZONE_INDEX_W-1:0];
               shadow_count++;
            end
         end
         OP_FIND: begin
            r.status = ST_NOT_FOUND;
            for (int i = 0; i < shadow_count; i++) begin
               z = shadow_zones[i];
               // equal velocity bounds = velocity don't-care
               if (z.instrument == b.instrument_id &&
                   b.note_key >= z.min_key && b.note_key <= z.max_key &&
                   (z.min_vel == z.max_vel ||
                    (b.note_velocity >= z.min_vel && b.note_velocity <= z.max_vel))) begin
                  r.status     = ST_OK;
                  r.zone_index = i[ZONE_INDEX_W-1:0];
                  break;
               end
            end
         end
         default: ;  // unused opcode: no state change
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Beat generators. Every beat starts fully random so all bits toggle,
   // then the fields that matter get shaped.
   // ------------------------------------------------------------------
   function automatic req_type random_beat();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic req_type zone_add_beat();
      req_type    b;
      logic [6:0] lo, hi, t;
      b = random_beat();
      b.opcode = OP_ADD;
      // small instrument pool so finds actually hit
      if ($urandom_range(0, 3) != 0)
         b.instrument_id = 8'($urandom_range(0, 3));
      lo = 7'($urandom_range(0, 127));
      hi = 7'($urandom_range(0, 127));
      if ($urandom_range(0, 9) < 8 && lo > hi) begin
         t = lo; lo = hi; hi = t;
      end
      b.zone_key_low  = lo;
      b.zone_key_high = hi;
      lo = 7'($urandom_range(0, 127));
      hi = 7'($urandom_range(0, 127));
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4: hi = lo;         // any velocity
         5, 6:          ;                // leave as drawn, maybe inverted
         default: if (lo > hi) begin
            t = lo; lo = hi; hi = t;
         end
      endcase
      b.zone_vel_low  = lo;
      b.zone_vel_high = hi;
      return b;
   endfunction

   // Find aimed at a stored zone: instrument, key, mostly velocity in range
   function automatic req_type aimed_find_beat();
      req_type  b;
      zone_type z;
      b = random_beat();
      b.opcode = OP_FIND;
      if (shadow_count == 0)
         return b;
      z = shadow_zones[$urandom_range(0, shadow_count - 1)];
      b.instrument_id = z.instrument;
      if (z.min_key <= z.max_key)
         b.note_key = 7'($urandom_range(z.min_key, z.max_key));
      if (z.min_vel < z.max_vel && $urandom_range(0, 4) != 0)
         b.note_velocity = 7'($urandom_range(z.min_vel, z.max_vel));
      return b;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // Sends one beat; on acceptance the expectation is queued. A typed
   // expectation overrides the shadow result, which still updates state.
   task automatic send_beat(input req_type b, input bit typed = 1'b0,
                            input rsp_type typed_rsp = '0);
      rsp_type predicted;
      if (tx_idle_en && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (!req_ready);
      predicted = apply_zone_cmd(b);
      owe_result(typed ? typed_rsp : predicted);
      if (b.opcode != OP_NOP)
         items_sent++;
   endtask

   // Hold the request side off until every owed result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
   endtask

   // clear, fill, then a burst of mostly aimed finds with some noise
   task automatic run_zone_sequence(input bit fill_up);
      req_type b;
      int      n_add;
      int      n_ops;
      int      pick;
      b = random_beat();
      b.opcode = OP_CLEAR;
      send_beat(b);
      // a fill goes past capacity to hit the table-full status
      n_add = fill_up ? TABLE_DEPTH + $urandom_range(1, 3) : $urandom_range(1, 12);
      for (int i = 0; i < n_add; i++)
         send_beat(zone_add_beat());
      n_ops = $urandom_range(4, 20);
      for (int i = 0; i < n_ops; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            b = aimed_find_beat();
         end else if (pick < 80) begin
            b = random_beat();
            b.opcode = OP_FIND;
         end else if (pick < 90) begin
            b = zone_add_beat();
         end else if (pick < 95) begin
            b = random_beat();
            b.opcode = OP_NOP;
         end else begin
            b = random_beat();  // anything, clear included
         end
         send_beat(b);
      end
   endtask

   // ------------------------------------------------------------------
   // Directed rows
   // ------------------------------------------------------------------
   typedef struct packed {
      req_type beat;
      logic    typed;
      rsp_type rsp;
   } dir_row_type;

   dir_row_type dir_rows [$];

   function automatic dir_row_type mk_row(input logic [1:0] op, input logic [7:0] inst,
                                          input logic [6:0] key, input logic [6:0] vel,
                                          input logic [6:0] klo, input logic [6:0] khi,
                                          input logic [6:0] vlo, input logic [6:0] vhi,
                                          input logic typed = 1'b0,
                                          input logic [1:0] st = ST_OK,
                                          input logic [ZONE_INDEX_W-1:0] idx = '0);
      dir_row_type r;
      r.beat = '{op, inst, key, vel, klo, khi, vlo, vhi};
      r.typed = typed;
      r.rsp = '{st, idx};
      return r;
   endfunction

   // Appends one row to the directed table
   function automatic void add_row(input dir_row_type r);
      dir_rows = {dir_rows, r};
   endfunction

   // ------------------------------------------------------------------
   // Result side: check each accepted beat, then drive ready for next edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_results.size() == 0) begin
            $display("%0t: unexpected result beat status=%0d zone_index=%0d",
                     $time, rsp_data.status, rsp_data.zone_index);
            mismatches++;
         end else begin
            want = owed_results.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, rsp_data.status);
               mismatches++;
            end
            if (rsp_data.zone_index !== want.zone_index) begin
               $display("%0t: zone_index mismatch: expected %0d, actual %0d",
                        $time, want.zone_index, rsp_data.zone_index);
               mismatches++;
            end
         end
      end
      // ready stalls come in short bursts
      if (rx_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rx_stall_left--;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         rx_stall_left = $urandom_range(0, 5);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int seq_num;

      // reset behavior, extremes, first-match order, inverted ranges
      add_row(mk_row(OP_FIND, 8'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
                     1'b1, ST_NOT_FOUND, 6'd0));
      add_row(mk_row(OP_NOP, 8'hFF, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F,
                     1'b1, ST_OK, 6'd0));
      add_row(mk_row(OP_ADD, 8'd0, 7'd0, 7'd0, 7'd0, 7'd127, 7'd0, 7'd0,
                     1'b1, ST_OK, 6'd0));
      add_row(mk_row(OP_FIND, 8'd0, 7'd127, 7'd127, 7'd0, 7'd0, 7'd0, 7'd0,
                     1'b1, ST_OK, 6'd0));
      add_row(mk_row(OP_ADD, 8'd255, 7'd0, 7'd0, 7'd127, 7'd127, 7'd0, 7'd127,
                     1'b1, ST_OK, 6'd1));
      add_row(mk_row(OP_FIND, 8'd255, 7'd127, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
                     1'b1, ST_OK, 6'd1));
      add_row(mk_row(OP_FIND, 8'd255, 7'd126, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
                     1'b1, ST_NOT_FOUND, 6'd0));
      add_row(mk_row(OP_FIND, 8'd254, 7'd127, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
                     1'b1, ST_NOT_FOUND, 6'd0));
      // inverted key range: stored, never matches
      add_row(mk_row(OP_ADD, 8'd255, 7'd0, 7'd0, 7'd10, 7'd5, 7'd3, 7'd3,
                     1'b1, ST_OK, 6'd2));
      add_row(mk_row(OP_FIND, 8'd255, 7'd7, 7'd3, 7'd0, 7'd0, 7'd0, 7'd0));
      // inverted velocity range with differing bounds: no velocity matches
      add_row(mk_row(OP_ADD, 8'd7, 7'd0, 7'd0, 7'd0, 7'd127, 7'd100, 7'd20,
                     1'b1, ST_OK, 6'd3));
      add_row(mk_row(OP_FIND, 8'd7, 7'd50, 7'd50, 7'd0, 7'd0, 7'd0, 7'd0));
      add_row(mk_row(OP_FIND, 8'd7, 7'd50, 7'd100, 7'd0, 7'd0, 7'd0, 7'd0));
      add_row(mk_row(OP_ADD, 8'd7, 7'd0, 7'd0, 7'd40, 7'd60, 7'd0, 7'd127,
                     1'b1, ST_OK, 6'd4));
      add_row(mk_row(OP_FIND, 8'd7, 7'd40, 7'd127, 7'd0, 7'd0, 7'd0, 7'd0));
      add_row(mk_row(OP_FIND, 8'd7, 7'd61, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0));
      // two zones cover key 60: lowest index wins
      add_row(mk_row(OP_ADD, 8'd7, 7'd0, 7'd0, 7'd60, 7'd60, 7'd64, 7'd64,
                     1'b1, ST_OK, 6'd5));
      add_row(mk_row(OP_FIND, 8'd7, 7'd60, 7'd1, 7'd0, 7'd0, 7'd0, 7'd0));
      // clear with every other field high
      add_row(mk_row(OP_CLEAR, 8'hFF, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F,
                     1'b1, ST_OK, 6'd0));
      add_row(mk_row(OP_FIND, 8'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
                     1'b1, ST_NOT_FOUND, 6'd0));
      add_row(mk_row(OP_ADD, 8'hA5, 7'd0, 7'd0, 7'd5, 7'd5, 7'd9, 7'd9,
                     1'b1, ST_OK, 6'd0));
      add_row(mk_row(OP_FIND, 8'hA5, 7'd5, 7'd127, 7'd0, 7'd0, 7'd0, 7'd0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].rsp);
      wait_drained();

      // random part; the first sequence fills the table to overflow
      seq_num = 0;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= QUIET_AFTER) begin
            tx_idle_en = 1'b0;
            rx_idle_en = 1'b0;
         end else begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
         end
         if (seq_num % 10 == 9) begin
            // pure noise burst, all opcodes
            repeat ($urandom_range(5, 15)) send_beat(random_beat());
         end else begin
            run_zone_sequence(seq_num == 0 || $urandom_range(0, 11) == 0);
         end
         if (seq_num % 8 == 4)
            wait_drained();
         seq_num++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && owed_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #(20_000_000);
      $display("Regression FAIL");
      $finish;
   end

endmodule
